/* src/dna_pkg.sv */
// Shared constants, codes and types of the descriptor number allocator.
package dna_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int NUM_W       = $clog2(TABLE_DEPTH);
   localparam int HW_W        = NUM_W + 1;
   localparam int WORD_BITS   = 16;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WORD_COUNT  = TABLE_DEPTH / WORD_BITS;
   localparam int WADDR_W     = $clog2(WORD_COUNT);
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;

   localparam logic [KIND_W-1:0] KIND_GET     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_FREE    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RANGE   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      OP_SET,
      OP_CLEAR,
      OP_SCAN
   } word_op_type;

   typedef struct packed {
      word_op_type        op;
      logic [WADDR_W-1:0] word;
      logic [NUM_W-1:0]   lo;
      logic [NUM_W-1:0]   hi;
   } word_req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] data;
      logic                 found;
      logic [NUM_W-1:0]     pos;
   } word_rsp_type;

endpackage

/* src/dna_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module dna_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/dna_word_unit.sv */
// Word modify logic: masks a number range in one map word and sets, clears or scans it.
module dna_word_unit
   import dna_pkg::*;
(
   input  word_req_type         req,
   input  logic [WORD_BITS-1:0] rd_data,
   output word_rsp_type         rsp
);

   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] cand;
   logic [WORD_BITS-1:0] first_hot;
   logic [NUM_W-1:0]     pos_b;
   logic [BIT_W-1:0]     idx;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         pos_b   = {req.word, BIT_W'(b)};
         mask[b] = (pos_b >= req.lo) && (pos_b <= req.hi);
      end
   end

   always_comb begin
      case (req.op)
         OP_CLEAR: cand = rd_data & mask;
         OP_SCAN:  cand = ~rd_data & mask;
         default:  cand = '0;
      endcase
   end

   assign first_hot = cand & (~cand + WORD_BITS'(1));

   always_comb begin
      idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (cand[b]) begin
            idx = BIT_W'(b);
         end
      end
   end

   always_comb begin
      case (req.op)
         OP_CLEAR: rsp.data = rd_data & ~mask;
         OP_SCAN:  rsp.data = rd_data | first_hot;
         default:  rsp.data = rd_data | mask;
      endcase
      rsp.found = |cand;
      rsp.pos   = {req.word, idx};
   end

endmodule

/* src/descriptor_number_allocator.sv */
// Top level of the descriptor number allocator: request sequencer around the used-map RAM.
//
// A request word is taken at a rising clock edge with start high and busy low.
// Kinds: get lowest free number, reserve a number, free a number, free a range.
// Each request yields exactly one response word, shown for one cycle with
// rsp_valid high; the receiver cannot stall, so the response is never held.
// The used map sits in a RAM of 16-bit words with a registered read. Requests read,
// modify and write one word at a time; a get writes only the word it grants from.
// Reserve and free go from idle through the read and evaluate states to the response.
// A get scans the map words from the hint up to the high-water mark for a free number
// and, if none is free there, takes the number at the mark or answers full.
// A range free clears the range one map word at a time across the words it spans.
// A whole-table free writes zeros to all 16 words without reading them.
// A reversed range answers from the idle state with the range status.
// After reset the block clears all 16 map words with busy high;
// the high-water mark and the hint reset to zero.
module descriptor_number_allocator
   import dna_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [NUM_W-1:0]    req_fd_number,
   input  logic [NUM_W-1:0]    req_range_last,
   input  logic                req_free_all,
   output logic                rsp_valid,
   output logic [NUM_W-1:0]    rsp_granted_number,
   output logic [STATUS_W-1:0] rsp_status
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_SWEEP
   } state_type;

   state_type            state_ff, state_in;
   word_op_type          op_ff, op_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [WADDR_W-1:0]   word_ff, word_in;
   logic [WADDR_W-1:0]   end_word_ff, end_word_in;
   logic [NUM_W-1:0]     lo_ff, lo_in;
   logic [NUM_W-1:0]     hi_ff, hi_in;
   logic [HW_W-1:0]      hw_ff, hw_in;
   logic [NUM_W-1:0]     hint_ff, hint_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]     rsp_granted_ff, rsp_granted_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic                 rd_en;
   logic [WADDR_W-1:0]   rd_addr;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic [WORD_BITS-1:0] rd_data;
   word_req_type         wu_req;
   word_rsp_type         wu_rsp;

   logic                 hw_full;
   logic [HW_W-1:0]      hw_dec;
   logic [NUM_W-1:0]     hw_low;
   logic [WADDR_W-1:0]   word_next;

   dna_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(WORD_COUNT)
   ) u_map (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(word_ff),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign wu_req.op   = op_ff;
   assign wu_req.word = word_ff;
   assign wu_req.lo   = lo_ff;
   assign wu_req.hi   = hi_ff;

   dna_word_unit u_word (
      .req    (wu_req),
      .rd_data(rd_data),
      .rsp    (wu_rsp)
   );

   assign hw_full   = (hw_ff == HW_W'(TABLE_DEPTH));
   assign hw_dec    = hw_ff - HW_W'(1);
   assign hw_low    = hw_ff[NUM_W-1:0];
   assign word_next = word_ff + WADDR_W'(1);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      kind_in        = kind_ff;
      word_in        = word_ff;
      end_word_in    = end_word_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      hw_in          = hw_ff;
      hint_in        = hint_ff;
      rsp_valid_in   = 1'b0;
      rsp_granted_in = '0;
      rsp_status_in  = STATUS_OK;
      rd_en          = 1'b0;
      rd_addr        = word_ff;
      wr_en          = 1'b0;
      wr_data        = wu_rsp.data;

      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = '0;
            word_in = word_next;
            if (word_ff == WADDR_W'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               kind_in = req_kind;
               case (req_kind)
                  KIND_GET: begin
                     if ({1'b0, hint_ff} < hw_ff) begin
                        op_in       = OP_SCAN;
                        lo_in       = hint_ff;
                        hi_in       = hw_dec[NUM_W-1:0];
                        word_in     = hint_ff[NUM_W-1:BIT_W];
                        end_word_in = hw_dec[NUM_W-1:BIT_W];
                        state_in    = ST_READ;
                     end else if (hw_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        op_in    = OP_SET;
                        lo_in    = hw_low;
                        hi_in    = hw_low;
                        word_in  = hw_low[NUM_W-1:BIT_W];
                        state_in = ST_READ;
                     end
                  end
                  KIND_RESERVE: begin
                     op_in    = OP_SET;
                     lo_in    = req_fd_number;
                     hi_in    = req_fd_number;
                     word_in  = req_fd_number[NUM_W-1:BIT_W];
                     state_in = ST_READ;
                  end
                  KIND_FREE: begin
                     op_in       = OP_CLEAR;
                     lo_in       = req_fd_number;
                     hi_in       = req_fd_number;
                     word_in     = req_fd_number[NUM_W-1:BIT_W];
                     end_word_in = req_fd_number[NUM_W-1:BIT_W];
                     state_in    = ST_READ;
                  end
                  default: begin
                     if (req_free_all) begin
                        word_in  = '0;
                        hint_in  = '0;
                        state_in = ST_SWEEP;
                     end else if (req_fd_number > req_range_last) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_RANGE;
                     end else begin
                        op_in       = OP_CLEAR;
                        lo_in       = req_fd_number;
                        hi_in       = req_range_last;
                        word_in     = req_fd_number[NUM_W-1:BIT_W];
                        end_word_in = req_range_last[NUM_W-1:BIT_W];
                        state_in    = ST_READ;
                     end
                  end
               endcase
            end
         end

         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EVAL;
         end

         ST_EVAL: begin
            case (op_ff)
               OP_SCAN: begin
                  if (wu_rsp.found) begin
                     wr_en          = 1'b1;
                     hint_in        = wu_rsp.pos;
                     rsp_valid_in   = 1'b1;
                     rsp_granted_in = wu_rsp.pos;
                     state_in       = ST_IDLE;
                  end else if (word_ff == end_word_ff) begin
                     if (hw_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STATUS_FULL;
                        state_in      = ST_IDLE;
                     end else begin
                        op_in    = OP_SET;
                        lo_in    = hw_low;
                        hi_in    = hw_low;
                        word_in  = hw_low[NUM_W-1:BIT_W];
                        state_in = ST_READ;
                     end
                  end else begin
                     word_in = word_next;
                     rd_en   = 1'b1;
                     rd_addr = word_next;
                  end
               end
               OP_SET: begin
                  wr_en = 1'b1;
                  if (kind_ff == KIND_GET) begin
                     rsp_granted_in = hw_low;
                     hw_in          = hw_ff + HW_W'(1);
                  end else if ({1'b0, lo_ff} >= hw_ff) begin
                     hw_in = {1'b0, lo_ff} + HW_W'(1);
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
               default: begin
                  wr_en = 1'b1;
                  if (kind_ff == KIND_FREE) begin
                     if (lo_ff < hint_ff) begin
                        hint_in = lo_ff;
                     end
                  end else if (wu_rsp.found && (wu_rsp.pos < hint_ff)) begin
                     hint_in = wu_rsp.pos;
                  end
                  if (word_ff == end_word_ff) begin
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end else begin
                     word_in = word_next;
                     rd_en   = 1'b1;
                     rd_addr = word_next;
                  end
               end
            endcase
         end

         ST_SWEEP: begin
            wr_en   = 1'b1;
            wr_data = '0;
            word_in = word_next;
            if (word_ff == WADDR_W'(WORD_COUNT - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         op_ff          <= OP_SET;
         kind_ff        <= KIND_GET;
         word_ff        <= '0;
         end_word_ff    <= '0;
         lo_ff          <= '0;
         hi_ff          <= '0;
         hw_ff          <= '0;
         hint_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_granted_ff <= '0;
         rsp_status_ff  <= STATUS_OK;
      end else begin
         state_ff       <= state_in;
         op_ff          <= op_in;
         kind_ff        <= kind_in;
         word_ff        <= word_in;
         end_word_ff    <= end_word_in;
         lo_ff          <= lo_in;
         hi_ff          <= hi_in;
         hw_ff          <= hw_in;
         hint_ff        <= hint_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_granted_ff <= rsp_granted_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_number = rsp_granted_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

/* sim/descriptor_number_allocator_tb.sv */
// Self-checking testbench of the descriptor number allocator: directed and random request words.
`timescale 1ns / 1ps

module descriptor_number_allocator_tb;
   import dna_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int QUIET_TAIL   = 100;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NUM_W-1:0]  fd_number;
      logic [NUM_W-1:0]  range_last;
      logic              free_all;
   } alloc_req_type;

   typedef struct packed {
      logic [NUM_W-1:0]    granted_number;
      logic [STATUS_W-1:0] status;
   } alloc_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = KIND_GET;
   logic [NUM_W-1:0]    req_fd_number = '0;
   logic [NUM_W-1:0]    req_range_last = '0;
   logic                req_free_all = 1'b0;
   logic                rsp_valid;
   logic [NUM_W-1:0]    rsp_granted_number;
   logic [STATUS_W-1:0] rsp_status;

   alloc_req_type pending_requests[$];
   alloc_rsp_type expected_responses[$];
   int            error_count = 0;
   int            cycle_count = 0;

   logic [TABLE_DEPTH-1:0] used_numbers = '0;
   logic [HW_W-1:0]        high_water   = '0;
   logic [NUM_W-1:0]       search_hint  = '0;

   descriptor_number_allocator i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_fd_number      (req_fd_number),
      .req_range_last     (req_range_last),
      .req_free_all       (req_free_all),
      .rsp_valid          (rsp_valid),
      .rsp_granted_number (rsp_granted_number),
      .rsp_status         (rsp_status)
   );

   // Applies one request word to the shadow allocator state and returns its response.
   function automatic alloc_rsp_type allocate_number(alloc_req_type w);
      alloc_rsp_type r;
      int            i;
      bit            found;
      r.granted_number = '0;
      r.status         = STATUS_OK;
      case (w.kind)
         KIND_GET: begin
            found = 0;
            for (i = int'(search_hint); i < int'(high_water) && i < TABLE_DEPTH && !found;
                 i++) begin
               if (!used_numbers[i]) begin
                  used_numbers[i]  = 1'b1;
                  search_hint      = i[NUM_W-1:0];
                  r.granted_number = i[NUM_W-1:0];
                  found            = 1;
               end
            end
            if (!found) begin
               if (int'(high_water) >= TABLE_DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  used_numbers[high_water] = 1'b1;
                  r.granted_number         = high_water[NUM_W-1:0];
                  high_water               = high_water + HW_W'(1);
               end
            end
         end
         KIND_RESERVE: begin
            used_numbers[w.fd_number] = 1'b1;
            if (int'(w.fd_number) >= int'(high_water)) begin
               high_water = HW_W'(int'(w.fd_number) + 1);
            end
         end
         KIND_FREE: begin
            used_numbers[w.fd_number] = 1'b0;
            if (w.fd_number < search_hint) begin
               search_hint = w.fd_number;
            end
         end
         default: begin
            if (w.free_all) begin
               used_numbers = '0;
               search_hint  = '0;
            end else if (w.fd_number > w.range_last) begin
               r.status = STATUS_RANGE;
            end else begin
               for (i = int'(w.fd_number); i <= int'(w.range_last); i++) begin
                  if (used_numbers[i]) begin
                     used_numbers[i] = 1'b0;
                     if (i < int'(search_hint)) begin
                        search_hint = i[NUM_W-1:0];
                     end
                  end
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic void queue_request(logic [KIND_W-1:0] kind, int num, int last_num, bit all);
      alloc_req_type w;
      w.kind       = kind;
      w.fd_number  = num[NUM_W-1:0];
      w.range_last = last_num[NUM_W-1:0];
      w.free_all   = all;
      pending_requests.push_back(w);
   endfunction

   // Builds a random request word; num_max bounds the numbers named by reserve and free.
   function automatic alloc_req_type random_request(int get_pct, int reserve_pct, int free_pct,
                                                    int num_max);
      alloc_req_type w;
      int            roll;
      int            span;
      roll         = int'($urandom_range(0, 99));
      w.fd_number  = NUM_W'($urandom_range(0, num_max));
      w.range_last = NUM_W'($urandom_range(0, TABLE_DEPTH - 1));
      w.free_all   = 1'($urandom_range(0, 1));
      if (roll < get_pct) begin
         w.kind      = KIND_GET;
         w.fd_number = NUM_W'($urandom_range(0, TABLE_DEPTH - 1));
      end else if (roll < get_pct + reserve_pct) begin
         w.kind = KIND_RESERVE;
      end else if (roll < get_pct + reserve_pct + free_pct) begin
         w.kind = KIND_FREE;
      end else begin
         w.kind     = KIND_RANGE;
         w.free_all = ($urandom_range(0, 24) == 0);
         case ($urandom_range(0, 5))
            0: begin
               w.range_last = '1;
            end
            1: begin
               w.range_last = NUM_W'($urandom_range(0, TABLE_DEPTH - 1));
            end
            default: begin
               span = int'(w.fd_number) + int'($urandom_range(0, 40));
               if (span > TABLE_DEPTH - 1) begin
                  span = TABLE_DEPTH - 1;
               end
               w.range_last = span[NUM_W-1:0];
            end
         endcase
      end
      return w;
   endfunction

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin : request_driver
      alloc_req_type w;
      alloc_req_type active_word;
      logic          drive_start;
      int            gap_cycles;
      if (reset) begin
         gap_cycles = 0;
         start <= 1'b0;
      end else begin
         drive_start = start;
         if (start && !busy) begin
            expected_responses.push_back(allocate_number(active_word));
            drive_start = 1'b0;
            if (pending_requests.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
               gap_cycles = int'($urandom_range(1, 9));
            end
         end
         if (!drive_start) begin
            if (gap_cycles > 0) begin
               gap_cycles--;
            end else if (pending_requests.size() > 0) begin
               w              = pending_requests.pop_front();
               active_word    = w;
               drive_start    = 1'b1;
               req_kind       <= w.kind;
               req_fd_number  <= w.fd_number;
               req_range_last <= w.range_last;
               req_free_all   <= w.free_all;
            end
         end
         start <= drive_start;
      end
   end

   always @(posedge clock) begin : response_monitor
      alloc_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_responses.size() == 0) begin
            $error("Unexpected response word: granted_number %0d, status %0d",
                   rsp_granted_number, rsp_status);
            error_count++;
         end else begin
            want = expected_responses.pop_front();
            if (rsp_granted_number !== want.granted_number) begin
               $error("granted_number mismatch: expected %0d, actual %0d",
                      want.granted_number, rsp_granted_number);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      int n;

      queue_request(KIND_GET, 0, 0, 1);
      queue_request(KIND_GET, 255, 255, 0);
      queue_request(KIND_GET, 0, 0, 0);
      queue_request(KIND_FREE, 1, 0, 1);
      queue_request(KIND_GET, 0, 0, 0);
      queue_request(KIND_FREE, 200, 0, 0);
      queue_request(KIND_RESERVE, 10, 255, 1);
      queue_request(KIND_RESERVE, 10, 0, 0);
      queue_request(KIND_GET, 0, 0, 0);
      queue_request(KIND_RANGE, 5, 2, 0);
      queue_request(KIND_RANGE, 0, 3, 0);
      queue_request(KIND_RANGE, 20, 30, 0);
      queue_request(KIND_GET, 0, 0, 0);
      queue_request(KIND_RANGE, 200, 100, 1);
      queue_request(KIND_GET, 0, 0, 0);
      queue_request(KIND_RESERVE, 255, 0, 0);
      queue_request(KIND_FREE, 255, 255, 0);
      queue_request(KIND_GET, 0, 0, 0);
      queue_request(KIND_RANGE, 250, 255, 0);
      queue_request(KIND_RANGE, 0, 255, 0);
      queue_request(KIND_GET, 128, 127, 1);
      queue_request(KIND_FREE, 0, 0, 0);

      // Small numbers first, so the mark climbs slowly and gets fall back to it.
      for (n = 0; n < 200; n++) begin
         pending_requests.push_back(random_request(50, 15, 20, 40));
      end

      // Clear the table and fill it past the top, so gets run into a full table.
      queue_request(KIND_RANGE, 0, 0, 1);
      for (n = 0; n < 280; n++) begin
         pending_requests.push_back(random_request(97, 0, 3, TABLE_DEPTH - 1));
      end

      for (n = 0; n < 400; n++) begin
         pending_requests.push_back(random_request(45, 15, 20, TABLE_DEPTH - 1));
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || start || expected_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
